### rtl/esro_pkg.sv
// shared types, constants and codes for the edge sort and row offset block
package esro_pkg;

    localparam int MaxEdges    = 1024;
    localparam int MaxNodes    = 1024;
    localparam int SwitchTypes = 64;

    localparam int EdgeAw = $clog2(MaxEdges);
    localparam int NodeW  = 10;
    localparam int SwW    = 6;
    localparam int CntW   = 11;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OpAppend    = 2'd0;
    localparam t_opcode OpPartition = 2'd1;
    localparam t_opcode OpReadEdge  = 2'd2;
    localparam t_opcode OpReadNode  = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status StOk     = 3'd0;
    localparam t_status StFull   = 3'd1;
    localparam t_status StLate   = 3'd2;
    localparam t_status StRange  = 3'd3;
    localparam t_status StNoPart = 3'd4;

    localparam logic CfgMask  = 1'b0;
    localparam logic CfgNodes = 1'b1;

    // one stored edge
    typedef struct packed {
        logic [NodeW-1:0] src;
        logic [NodeW-1:0] dest;
        logic [SwW-1:0]   sw;
    } t_edge;

    // sort key: source, non-configurable flag, destination, switch
    function automatic logic [26:0] sort_key(input t_edge e, input logic [63:0] mask);
        sort_key = {e.src, ~mask[e.sw], e.dest, e.sw};
    endfunction

endpackage

### rtl/esro_edge_ram.sv
// single port edge memory with registered read data
module esro_edge_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [esro_pkg::EdgeAw-1:0] i_addr,
    input  esro_pkg::t_edge             i_wdata,
    output esro_pkg::t_edge             o_rdata
);
    esro_pkg::t_edge r_mem [esro_pkg::MaxEdges];

    // write or read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/esro_offset_ram.sv
// row offset memory with registered read data
module esro_offset_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [esro_pkg::NodeW:0]  i_addr,
    input  logic [esro_pkg::CntW-1:0] i_wdata,
    output logic [esro_pkg::CntW-1:0] o_rdata
);
    logic [esro_pkg::CntW-1:0] r_mem [esro_pkg::MaxNodes+1];

    // write or read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/edge_sort_and_row_offsets_top.sv
// top level: command sequencer over the edge and row offset memories
// Each transaction yields one result, held in a result register until it is taken.
// Appends, repeated partitions and every rejected request pass straight to the done state
// and then to the result register. Read edge passes through a read wait state and a read
// state. Read node reads the node's two offsets, then checks each configurable leading edge
// of the node. Partition runs an insertion sort over the single edge memory port, then
// fills node_count+1 offset entries. Input stalls while a transaction runs and while an
// untaken result waits.
module edge_sort_and_row_offsets_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [9:0]  i_src_node,
    input  logic [9:0]  i_dest_node,
    input  logic [5:0]  i_switch_type,
    input  logic [9:0]  i_edge_index,
    input  logic [9:0]  i_query_node,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [9:0]  o_out_src,
    output logic [9:0]  o_out_dest,
    output logic [5:0]  o_out_switch,
    output logic [10:0] o_start_edge,
    output logic [10:0] o_node_edges,
    output logic [10:0] o_configurable_edges,
    output logic [10:0] o_total_edges
);
    localparam int Aw = esro_pkg::EdgeAw;
    localparam int Cw = esro_pkg::CntW;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_RDWAIT = 13'b0000000000010,
        S_RDEDGE = 13'b0000000000100,
        S_NOFF1  = 13'b0000000001000,
        S_NOFF2  = 13'b0000000010000,
        S_NSCAN  = 13'b0000000100000,
        S_SREADI = 13'b0000001000000,
        S_SHOLD  = 13'b0000010000000,
        S_SREADJ = 13'b0000100000000,
        S_SCMP   = 13'b0001000000000,
        S_OREAD  = 13'b0010000000000,
        S_OCHK   = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    t_state r_state;

    logic [63:0]   r_mask;
    logic [Cw-1:0] r_nodes;
    logic [Cw-1:0] r_total;
    logic          r_part;

    logic            r_ovalid;
    esro_pkg::t_status r_status;
    esro_pkg::t_edge r_oedge;
    logic [Cw-1:0]   r_first, r_count, r_conf;

    // sort and scan working registers
    esro_pkg::t_edge r_key_edge;
    logic [Cw-1:0]   r_i, r_j, r_k, r_last, r_n;

    logic            e_we;
    logic [Aw-1:0]   e_addr;
    esro_pkg::t_edge e_wdata, e_rdata;
    logic            ofs_we;
    logic [esro_pkg::NodeW:0] ofs_addr;
    logic [Cw-1:0]   ofs_wdata, ofs_rdata;

    esro_edge_ram u_edges (
        .i_clk(i_clk), .i_we(e_we), .i_addr(e_addr), .i_wdata(e_wdata), .o_rdata(e_rdata)
    );
    esro_offset_ram u_offs (
        .i_clk(i_clk), .i_we(ofs_we), .i_addr(ofs_addr), .i_wdata(ofs_wdata),
        .o_rdata(ofs_rdata)
    );

    logic in_acc;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign in_acc  = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    logic [Cw-1:0] src_ext, dst_ext, eix_ext, qn_ext;
    assign src_ext = {1'b0, i_src_node};
    assign dst_ext = {1'b0, i_dest_node};
    assign eix_ext = {1'b0, i_edge_index};
    assign qn_ext  = {1'b0, i_query_node};

    logic key_gt;
    assign key_gt = esro_pkg::sort_key(e_rdata, r_mask)
                  > esro_pkg::sort_key(r_key_edge, r_mask);

    // memory port control
    always_comb begin
        e_we      = 1'b0;
        e_addr    = r_i[Aw-1:0];
        e_wdata   = r_key_edge;
        ofs_we    = 1'b0;
        ofs_addr  = r_n[esro_pkg::NodeW:0];
        ofs_wdata = r_i;
        unique case (r_state)
            S_IDLE: begin
                e_addr = i_edge_index[Aw-1:0];
                e_wdata = {i_src_node, i_dest_node, i_switch_type};
                if (in_acc && i_opcode == esro_pkg::OpAppend) begin
                    e_addr = r_total[Aw-1:0];
                    e_we = !r_part && r_total < Cw'(esro_pkg::MaxEdges)
                        && src_ext < r_nodes && dst_ext < r_nodes;
                end
                if (in_acc && i_opcode == esro_pkg::OpReadNode) begin
                    ofs_addr = {1'b0, i_query_node} + 11'd1;
                end
            end
            S_RDWAIT, S_RDEDGE: e_addr = r_i[Aw-1:0];
            S_NOFF1: ofs_addr = r_n[esro_pkg::NodeW:0];
            // start the scan at the node's first edge
            S_NOFF2: e_addr = ofs_rdata[Aw-1:0];
            // fetch the following edge while the current one is checked
            S_NSCAN: e_addr = Aw'(r_k + 11'd1);
            S_SREADI: e_addr = r_i[Aw-1:0];
            S_SHOLD, S_SREADJ: e_addr = Aw'(r_j - 11'd1);
            S_SCMP: begin
                e_we = 1'b1;
                e_addr = r_j[Aw-1:0];
                if (r_j != '0 && key_gt) begin
                    e_wdata = e_rdata;
                end else begin
                    e_wdata = r_key_edge;
                end
            end
            S_OREAD: e_addr = r_i[Aw-1:0];
            S_OCHK: begin
                e_addr = r_i[Aw-1:0];
                if (!(r_i < r_total && {1'b0, e_rdata.src} < r_n)) begin
                    ofs_we = 1'b1;
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mask   <= '1;
            r_nodes  <= Cw'(esro_pkg::MaxNodes);
            r_total  <= '0;
            r_part   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // result register: set on completion, cleared once taken
            if (r_state == S_DONE) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == esro_pkg::CfgMask) begin
                    r_mask <= i_cfg_data;
                end else if (!r_part) begin
                    if (i_cfg_data[10:0] == '0) begin
                        r_nodes <= 11'd1;
                    end else if (i_cfg_data[10:0] > Cw'(esro_pkg::MaxNodes)) begin
                        r_nodes <= Cw'(esro_pkg::MaxNodes);
                    end else begin
                        r_nodes <= i_cfg_data[10:0];
                    end
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_oedge  <= '0;
                        r_first  <= '0;
                        r_count  <= '0;
                        r_conf   <= '0;
                        unique case (i_opcode)
                            esro_pkg::OpAppend: begin
                                r_state <= S_DONE;
                                if (r_part) begin
                                    r_status <= esro_pkg::StLate;
                                end else if (r_total >= Cw'(esro_pkg::MaxEdges)) begin
                                    r_status <= esro_pkg::StFull;
                                end else if (src_ext >= r_nodes || dst_ext >= r_nodes) begin
                                    r_status <= esro_pkg::StRange;
                                end else begin
                                    r_status <= esro_pkg::StOk;
                                    r_total  <= r_total + 11'd1;
                                end
                            end
                            esro_pkg::OpPartition: begin
                                r_status <= esro_pkg::StOk;
                                r_n <= '0;
                                if (r_part) begin
                                    r_i <= '0;
                                    r_state <= S_DONE;
                                end else if (r_total > 11'd1) begin
                                    r_i <= 11'd1;
                                    r_state <= S_SREADI;
                                end else begin
                                    r_i <= '0;
                                    r_state <= S_OREAD;
                                end
                            end
                            esro_pkg::OpReadEdge: begin
                                r_i <= eix_ext;
                                if (!r_part) begin
                                    r_status <= esro_pkg::StNoPart;
                                    r_state <= S_DONE;
                                end else if (eix_ext >= r_total) begin
                                    r_status <= esro_pkg::StRange;
                                    r_state <= S_DONE;
                                end else begin
                                    r_status <= esro_pkg::StOk;
                                    r_state <= S_RDWAIT;
                                end
                            end
                            esro_pkg::OpReadNode: begin
                                r_n <= qn_ext;
                                if (!r_part) begin
                                    r_status <= esro_pkg::StNoPart;
                                    r_state <= S_DONE;
                                end else if (qn_ext >= r_nodes) begin
                                    r_status <= esro_pkg::StRange;
                                    r_state <= S_DONE;
                                end else begin
                                    r_status <= esro_pkg::StOk;
                                    r_state <= S_NOFF1;
                                end
                            end
                        endcase
                    end
                end
                S_RDWAIT: r_state <= S_RDEDGE;
                S_RDEDGE: begin
                    r_oedge <= e_rdata;
                    r_state <= S_DONE;
                end
                S_NOFF1: begin
                    r_last  <= ofs_rdata;
                    r_state <= S_NOFF2;
                end
                S_NOFF2: begin
                    r_first <= ofs_rdata;
                    r_k     <= ofs_rdata;
                    r_last  <= (r_last < ofs_rdata) ? ofs_rdata : r_last;
                    r_state <= S_NSCAN;
                end
                S_NSCAN: begin
                    // read data holds edge r_k; stop at the range end or a fixed switch
                    if (r_k >= r_last || !r_mask[e_rdata.sw]) begin
                        r_count <= r_last - r_first;
                        r_conf  <= r_k - r_first;
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + 11'd1;
                    end
                end
                S_SREADI: begin
                    r_j <= r_i;
                    r_state <= S_SHOLD;
                end
                S_SHOLD: begin
                    r_key_edge <= e_rdata;
                    r_state <= S_SREADJ;
                end
                S_SREADJ: r_state <= S_SCMP;
                S_SCMP: begin
                    if (r_j != '0 && key_gt) begin
                        r_j <= r_j - 11'd1;
                        r_state <= (r_j == 11'd1) ? S_SCMP : S_SREADJ;
                    end else if (r_i + 11'd1 < r_total) begin
                        r_i <= r_i + 11'd1;
                        r_state <= S_SREADI;
                    end else begin
                        r_i <= '0;
                        r_n <= '0;
                        r_state <= S_OREAD;
                    end
                end
                S_OREAD: r_state <= S_OCHK;
                S_OCHK: begin
                    if (r_i < r_total && {1'b0, e_rdata.src} < r_n) begin
                        r_i <= r_i + 11'd1;
                        r_state <= S_OREAD;
                    end else if (r_n >= r_nodes) begin
                        r_part <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_n <= r_n + 11'd1;
                        r_state <= S_OREAD;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid              = r_ovalid;
    assign o_status             = r_status;
    assign o_out_src            = r_oedge.src;
    assign o_out_dest           = r_oedge.dest;
    assign o_out_switch         = r_oedge.sw;
    assign o_start_edge         = r_first;
    assign o_node_edges         = r_count;
    assign o_configurable_edges = r_conf;
    assign o_total_edges        = r_total;

    // total never exceeds capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= Cw'(esro_pkg::MaxEdges)) else $error("edge total overflow");
    // no new transaction while any transaction runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    // partitioned flag never clears
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_part) |-> r_part) else $error("partition flag dropped");
endmodule
